// File: sv/rcpw_pkg.sv
// ---------------------------------------------------------------------------
// rcpw_pkg : shared definitions for the RC pulse-width capture unit
// Field widths, register reset values, register map, state and status types.
// ---------------------------------------------------------------------------
package rcpw_pkg;

  // Parameter defaults
  localparam int CHANNELS_DEF     = 4;
  localparam int COUNTER_BITS_DEF = 16;

  // Field widths
  localparam int CH_W     = 2;   // channel number
  localparam int CAP_W    = 16;  // capture value
  localparam int PERIOD_W = 17;  // counter period register
  localparam int CLK_W    = 8;   // reference clock in MHz
  localparam int US_W     = 16;  // microsecond registers
  localparam int FRAC_W   = 4;   // Q4 fraction bits
  localparam int PW_W     = 21;  // pulse width result
  localparam int DIFF_W   = PERIOD_W + 1;     // wrapped tick difference
  localparam int Q_W      = DIFF_W + FRAC_W;  // full quotient
  localparam int LIM_W    = US_W + FRAC_W;    // thresholds in Q4

  // Register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(65536);
  localparam logic [CLK_W-1:0]    CLK_RST    = CLK_W'(1);
  localparam logic [US_W-1:0]     PMAX_RST   = US_W'(2100);
  localparam logic [US_W-1:0]     FRAME_RST  = US_W'(20000);

  // Configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_CLK    = 2'd1,
    REG_PMAX   = 2'd2,
    REG_FRAME  = 2'd3
  } rcpw_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF,
    ST_DIV,
    ST_POST
  } rcpw_state_e;

  // Edge tracker to sequencer
  typedef struct packed {
    logic            pair_done;  // accepted item closes a pulse
    logic [CH_W-1:0] channel;    // channel of the latched pair
  } edge_stat_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;  // last quotient bit is written at this edge
  } div_stat_t;

endpackage

// File: sv/rcpw_edge_track.sv
// ---------------------------------------------------------------------------
// rcpw_edge_track : per-channel edge pairing and tick difference
// Stores the first capture of each channel, latches the pair on the second
// and forms the difference, wrapping through the counter period.
// ---------------------------------------------------------------------------
module rcpw_edge_track
  import rcpw_pkg::*;
#(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [CH_W-1:0]     channel_i,
  input  logic [CAP_W-1:0]    capture_value_i,
  input  logic [PERIOD_W-1:0] period_i,
  output edge_stat_t          stat_o,
  output logic [DIFF_W-1:0]   diff_o
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int VAL_W = (COUNTER_BITS < CAP_W) ? COUNTER_BITS : CAP_W;

  logic [CHANNELS-1:0] seen_q;
  logic [VAL_W-1:0]    first_mem [CHANNELS];
  logic [VAL_W-1:0]    val_q, first_q;
  logic [CH_W-1:0]     ch_q;

  logic                ch_ok;
  logic [IDX_W-1:0]    ch_idx;
  logic [VAL_W-1:0]    val_m;
  logic                pair;
  logic [PERIOD_W-1:0] first_ext, head;

  assign ch_ok  = 32'(channel_i) < CHANNELS;
  assign ch_idx = IDX_W'(channel_i);
  assign val_m  = VAL_W'(capture_value_i);
  assign pair   = fire_i && ch_ok && seen_q[ch_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (fire_i && ch_ok) begin
      seen_q[ch_idx] <= !seen_q[ch_idx];
    end
  end

  // first-edge store and pair latch: payload only
  always_ff @(posedge clk_i) begin
    if (fire_i && ch_ok && !seen_q[ch_idx]) begin
      first_mem[ch_idx] <= val_m;
    end
    if (pair) begin
      val_q   <= val_m;
      first_q <= first_mem[ch_idx];
      ch_q    <= channel_i;
    end
  end

  // wrap: (period - first) saturating at zero, plus second value
  always_comb begin
    first_ext = PERIOD_W'(first_q);
    head      = (period_i > first_ext) ? (period_i - first_ext) : '0;
    if (val_q > first_q) begin
      diff_o = DIFF_W'(val_q - first_q);
    end else begin
      diff_o = DIFF_W'(head) + DIFF_W'(val_q);
    end
  end

  assign stat_o.pair_done = pair;
  assign stat_o.channel   = ch_q;

endmodule

// File: sv/rcpw_serial_div.sv
// ---------------------------------------------------------------------------
// rcpw_serial_div : bit-serial restoring divider
// One quotient bit per cycle; dividend shifts out MSB first while the
// quotient shifts in behind it.
// ---------------------------------------------------------------------------
module rcpw_serial_div
  import rcpw_pkg::*;
#(
  parameter int NUM_W = Q_W,
  parameter int DEN_W = CLK_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] dq_q, dq_d;
  logic [DEN_W-1:0] rem_q, rem_d, dvs_q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, dq_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? DEN_W'(rem_sh - {1'b0, dvs_q}) : DEN_W'(rem_sh);
    dq_d   = {dq_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= (divisor_i == '0) ? DEN_W'(1) : divisor_i;  // zero clock acts as one
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == CNT_W'(1));
  assign quotient_o  = dq_q;

endmodule

// File: sv/rc_pwm_pulse_width_capture_unit.sv
// ---------------------------------------------------------------------------
// rc_pwm_pulse_width_capture_unit : four-channel RC PWM pulse-width capture
// The pair is latched at the accepting edge; the difference state starts a
// bit-serial divide over Q_W = 22 quotient bits; threshold/invert feeds the
// output register. The serial divider is the bottleneck: no capture is taken
// until the last pulse is loaded into the output register. Opening captures
// and out-of-range channels give no result. Async active-low reset clears
// the control state, edge-seen flags, config registers and output valid.
// ---------------------------------------------------------------------------
module rc_pwm_pulse_width_capture_unit
  import rcpw_pkg::*;
#(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // capture items in
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [15:0]       s_axis_tdata_i,   // [15:0] capture_value
  input  logic [1:0]        s_axis_tuser_i,   // [1:0] channel
  // pulse width items out
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [23:0]       m_axis_tdata_o,   // [20:0] pulse_width_q4, [23:21] zero
  output logic [2:0]        m_axis_tuser_o,   // [1:0] out_channel, [2] was_inverted
  // configuration
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output logic [APB_DW-1:0] prdata_o,
  output logic              pready_o
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [PERIOD_W-1:0] period_q;
  logic [CLK_W-1:0]    clk_mhz_q;
  logic [US_W-1:0]     pmax_q, frame_q;
  logic                cfg_wr;
  rcpw_reg_e           reg_sel;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign reg_sel  = rcpw_reg_e'(paddr_i[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PERIOD_RST;
      clk_mhz_q <= CLK_RST;
      pmax_q    <= PMAX_RST;
      frame_q   <= FRAME_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_PERIOD: period_q  <= pwdata_i[PERIOD_W-1:0];
        REG_CLK:    clk_mhz_q <= pwdata_i[CLK_W-1:0];
        REG_PMAX:   pmax_q    <= pwdata_i[US_W-1:0];
        REG_FRAME:  frame_q   <= pwdata_i[US_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PERIOD: prdata_o = APB_DW'(period_q);
      REG_CLK:    prdata_o = APB_DW'(clk_mhz_q);
      REG_PMAX:   prdata_o = APB_DW'(pmax_q);
      REG_FRAME:  prdata_o = APB_DW'(frame_q);
      default:    prdata_o = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  rcpw_state_e state_q, state_d;
  edge_stat_t  edge_stat;
  div_stat_t   div_stat;
  logic [DIFF_W-1:0] diff;
  logic [Q_W-1:0]    quot;
  logic in_fire, div_start, out_load;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (edge_stat.pair_done) state_d = ST_DIFF;
      end
      ST_DIFF: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) state_d = ST_POST;
      end
      ST_POST: begin
        // hold the finished quotient until the output slot frees up
        if (!m_axis_tvalid_o || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  rcpw_edge_track #(
    .CHANNELS     (CHANNELS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_edge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (in_fire),
    .channel_i       (s_axis_tuser_i),
    .capture_value_i (s_axis_tdata_i),
    .period_i        (period_q),
    .stat_o          (edge_stat),
    .diff_o          (diff)
  );

  // q4 = diff * 16 / timer MHz, one bit per cycle
  rcpw_serial_div #(
    .NUM_W (Q_W),
    .DEN_W (CLK_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({diff, {FRAC_W{1'b0}}}),
    .divisor_i  (clk_mhz_q),
    .stat_o     (div_stat),
    .quotient_o (quot)
  );

  // ---------------------------------------------------------------------
  // Threshold and inversion, output register
  // ---------------------------------------------------------------------
  logic [Q_W-1:0]  limit, frame;
  logic            inv;
  logic [Q_W-1:0]  width;
  logic            out_valid_q;
  logic [PW_W-1:0] out_pw_q;
  logic [CH_W-1:0] out_ch_q;
  logic            out_inv_q;

  always_comb begin
    limit = Q_W'({pmax_q, {FRAC_W{1'b0}}});
    frame = Q_W'({frame_q, {FRAC_W{1'b0}}});
    inv   = quot > limit;   // compared on the full quotient, before truncation
    if (inv) begin
      width = (frame > quot) ? (frame - quot) : '0;
    end else begin
      width = quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pw_q  <= width[PW_W-1:0];
      out_ch_q  <= edge_stat.channel;
      out_inv_q <= inv;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(24 - PW_W){1'b0}}, out_pw_q};
  assign m_axis_tuser_o  = {out_inv_q, out_ch_q};

  logic unused_busy;
  assign unused_busy = div_stat.busy;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb : testbench for the RC PWM pulse-width capture unit
// Drives capture items into the slave stream, writes and reads back the
// APB registers, predicts every pulse width in the testbench and checks each
// result item in order against the oldest prediction. Directed pairs, corner
// configurations, a long output stall and random phases with idle bursts.
// ---------------------------------------------------------------------------
module tb;
  import rcpw_pkg::*;

  localparam int DRAIN_CYCLES = 40;       // longer than the closing latency
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 300;      // long output stall

  // Expected result item
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [PW_W-1:0] width_q4;
    logic            inverted;
  } pulse_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  // Capture stream
  logic              s_valid;
  logic              s_axis_tready_o;
  logic [15:0]       s_data;   // [15:0] capture_value
  logic [1:0]        s_user;   // [1:0] channel
  // Pulse width stream
  logic              m_axis_tvalid_o;
  logic              m_ready;
  logic [23:0]       m_axis_tdata_o;  // [20:0] pulse_width_q4
  logic [2:0]        m_axis_tuser_o;  // [1:0] out_channel, [2] was_inverted
  // APB
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata_o;
  logic              pready_o;

  // Predictor state: register copies and per-channel opening edge
  logic [PERIOD_W-1:0] cfg_period;
  logic [CLK_W-1:0]    cfg_clk;
  logic [US_W-1:0]     cfg_pmax;
  logic [US_W-1:0]     cfg_frame;
  logic [3:0]          edge_open;
  logic [CAP_W-1:0]    edge_start [4];

  pulse_t pending_widths [$];

  int errors = 0;
  int cycles = 0;
  int hold_len = 0;   // set by a test, consumed by the sink process
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;

  rc_pwm_pulse_width_capture_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rc_pwm_pulse_width_capture_unit test failed");
      $finish;
    end
  end

  // Width of a closed pulse in Q4 us, with wrap and inversion applied.
  function automatic pulse_t measure_pulse(input logic [CH_W-1:0] ch,
                                           input logic [CAP_W-1:0] start,
                                           input logic [CAP_W-1:0] stop);
    logic [DIFF_W-1:0]   ticks;
    logic [PERIOD_W-1:0] head;
    logic [CLK_W-1:0]    divisor;
    logic [Q_W-1:0]      q4;
    logic [Q_W-1:0]      limit;
    logic [Q_W-1:0]      frame;
    pulse_t              r;
    if (stop > start) begin
      ticks = DIFF_W'(stop - start);
    end else begin
      // wrap through the period; a period at or below the start adds nothing
      head  = (cfg_period > PERIOD_W'(start)) ? cfg_period - PERIOD_W'(start) : '0;
      ticks = DIFF_W'(head) + DIFF_W'(stop);
    end
    divisor = (cfg_clk == '0) ? CLK_W'(1) : cfg_clk;
    q4      = (Q_W'(ticks) * Q_W'(16)) / Q_W'(divisor);
    limit   = Q_W'({cfg_pmax, 4'b0000});
    frame   = Q_W'({cfg_frame, 4'b0000});
    r.ch       = ch;
    r.inverted = 1'b0;
    if (q4 > limit) begin
      r.inverted = 1'b1;
      q4 = (frame > q4) ? frame - q4 : '0;  // saturates at zero
    end
    r.width_q4 = q4[PW_W-1:0];
    return r;
  endfunction

  // Result checker: outputs sampled at the rising edge
  always @(posedge clk_i) begin
    pulse_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_widths.size() == 0) begin
        $display("%0t: unexpected item ch=%0d width=%0d inv=%0d", $time,
                 m_axis_tuser_o[1:0], m_axis_tdata_o, m_axis_tuser_o[2]);
        errors++;
      end else begin
        want = pending_widths.pop_front();
        if (m_axis_tuser_o[1:0] !== want.ch) begin
          $display("%0t: channel expected %0d actual %0d", $time, want.ch,
                   m_axis_tuser_o[1:0]);
          errors++;
        end
        // upper tdata bits are padding and must read zero
        if (m_axis_tdata_o !== {3'b000, want.width_q4}) begin
          $display("%0t: width_q4 (ch %0d) expected %0d actual %0d", $time, want.ch,
                   want.width_q4, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tuser_o[2] !== want.inverted) begin
          $display("%0t: was_inverted (ch %0d) expected %0d actual %0d", $time,
                   want.ch, want.inverted, m_axis_tuser_o[2]);
          errors++;
        end
      end
    end
  end

  // Sink: ready changes at the falling edge. Random stall bursts when enabled,
  // and a long hold-off counted here when a test asks for one.
  initial begin
    int n;
    forever begin
      if (hold_len > 0) begin
        m_ready <= 1'b0;
        n = hold_len;
        hold_len = 0;
        repeat (n) @(negedge clk_i);
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end else begin
        m_ready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  // Update the predictor for one accepted capture item.
  task automatic note_capture(input logic [CH_W-1:0] ch, input logic [CAP_W-1:0] val);
    if (!edge_open[ch]) begin
      edge_open[ch]  = 1'b1;
      edge_start[ch] = val;
    end else begin
      pending_widths.push_back(measure_pulse(ch, edge_start[ch], val));
      edge_open[ch] = 1'b0;
    end
  endtask

  // Offer one capture item; returns at the accepting rising edge. Valid stays
  // high so back-to-back items keep the bus busy; settle() lowers it.
  task automatic send_capture(input logic [CH_W-1:0] ch, input logic [CAP_W-1:0] val);
    @(negedge clk_i);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= val;
    s_user  <= ch;
    do @(posedge clk_i); while (!s_axis_tready_o);
    note_capture(ch, val);
  endtask

  // Stop offering, let every expected result drain, then allow the pipe to empty.
  task automatic settle();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_widths.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input rcpw_reg_e idx,
                          input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    rdata = prdata_o;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register (block idle), mirror it, and check the read-back.
  task automatic write_reg(input rcpw_reg_e idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] rd;
    logic [APB_DW-1:0] want;
    apb_xfer(1'b1, idx, value, rd);
    case (idx)
      REG_PERIOD: begin
        cfg_period = value[PERIOD_W-1:0];
        want = APB_DW'(cfg_period);
      end
      REG_CLK: begin
        cfg_clk = value[CLK_W-1:0];
        want = APB_DW'(cfg_clk);
      end
      REG_PMAX: begin
        cfg_pmax = value[US_W-1:0];
        want = APB_DW'(cfg_pmax);
      end
      default: begin
        cfg_frame = value[US_W-1:0];
        want = APB_DW'(cfg_frame);
      end
    endcase
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== want) begin
      $display("%0t: read-back of %s expected %0d actual %0d", $time, idx.name(), want, rd);
      errors++;
    end
  endtask

  // Random register set, extremes weighted in; sometimes with junk upper bits.
  task automatic random_config();
    case ($urandom_range(0, 4))
      0:       write_reg(REG_PERIOD, 32'd65536);
      1:       write_reg(REG_PERIOD, $urandom_range(1, 65536));
      2:       write_reg(REG_PERIOD, $urandom_range(0, 131071));
      3:       write_reg(REG_PERIOD, $urandom_range(1, 70));
      default: write_reg(REG_PERIOD, $urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       write_reg(REG_CLK, 32'd1);
      1:       write_reg(REG_CLK, 32'd255);
      2:       write_reg(REG_CLK, 32'd0);
      default: write_reg(REG_CLK, $urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       write_reg(REG_PMAX, 32'd2100);
      1:       write_reg(REG_PMAX, {$urandom_range(0, 1)} * 32'd65535);
      default: write_reg(REG_PMAX, $urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       write_reg(REG_FRAME, 32'd20000);
      1:       write_reg(REG_FRAME, {$urandom_range(0, 1)} * 32'd65535);
      default: write_reg(REG_FRAME, $urandom);
    endcase
  endtask

  // Random captures. Mostly the closing edge lands a plausible pulse after
  // the opening one; the rest are arbitrary counter values.
  task automatic random_captures(input int count);
    logic [CH_W-1:0]  ch;
    logic [CAP_W-1:0] val;
    int               tick_rate;
    for (int i = 0; i < count; i++) begin
      ch = CH_W'($urandom_range(0, 3));
      tick_rate = (cfg_clk == '0) ? 1 : int'(cfg_clk);
      if (edge_open[ch] && $urandom_range(0, 2) != 0) begin
        val = edge_start[ch] + CAP_W'($urandom_range(0, 2600) * tick_rate);
      end else begin
        val = CAP_W'($urandom);
      end
      send_capture(ch, val);
    end
  endtask

  // Reset defaults: plain pulses, a wrap, equal captures, the threshold edge.
  task automatic test_directed_pairs();
    send_capture(2'd0, 16'd1000);
    send_capture(2'd0, 16'd2500);    // 1500 us, below threshold
    send_capture(2'd1, 16'd65000);
    send_capture(2'd1, 16'd100);     // wraps through the period
    send_capture(2'd2, 16'd5000);
    send_capture(2'd2, 16'd5000);    // equal: full period, inversion floors at 0
    send_capture(2'd3, 16'd0);
    send_capture(2'd3, 16'd2200);    // above maximum, inverted
    send_capture(2'd0, 16'd0);
    send_capture(2'd1, 16'd65535);
    send_capture(2'd0, 16'd65535);   // interleaved pulses
    send_capture(2'd1, 16'd0);
    send_capture(2'd2, 16'd10);
    send_capture(2'd2, 16'd2110);    // exactly at the maximum, not inverted
    send_capture(2'd3, 16'd10);
    send_capture(2'd3, 16'd2111);    // one tick over, inverted
    send_capture(2'd0, 16'hAAAA);
    send_capture(2'd0, 16'hAAAA + 16'd1);
    send_capture(2'd1, 16'h5555);
    send_capture(2'd1, 16'h5555 + 16'd1500);
    settle();
  endtask

  // Register corners: period below the opening value, zero period and clock,
  // truncating divide, zero and full thresholds and frames.
  task automatic test_corner_configs();
    write_reg(REG_PERIOD, 32'd100);
    send_capture(2'd0, 16'd5000);
    send_capture(2'd0, 16'd10);      // wrap head saturates, width = second value
    settle();
    write_reg(REG_PERIOD, 32'd0);
    send_capture(2'd1, 16'd300);
    send_capture(2'd1, 16'd200);
    send_capture(2'd2, 16'd10);
    send_capture(2'd2, 16'd20);
    settle();
    write_reg(REG_PERIOD, 32'd1);
    send_capture(2'd3, 16'd0);
    send_capture(2'd3, 16'd0);
    settle();
    write_reg(REG_PERIOD, 32'd131071);
    write_reg(REG_CLK, 32'd0);       // zero divisor acts as one
    send_capture(2'd0, 16'd65535);
    send_capture(2'd0, 16'd0);
    send_capture(2'd1, 16'd0);
    send_capture(2'd1, 16'd100);
    settle();
    write_reg(REG_CLK, 32'd255);
    write_reg(REG_PERIOD, 32'd65536);
    send_capture(2'd2, 16'd0);
    send_capture(2'd2, 16'd65535);
    settle();
    write_reg(REG_CLK, 32'd1);
    write_reg(REG_PMAX, 32'd0);
    send_capture(2'd3, 16'd0);
    send_capture(2'd3, 16'd1);       // any width is inverted
    settle();
    write_reg(REG_FRAME, 32'd0);
    send_capture(2'd0, 16'd0);
    send_capture(2'd0, 16'd1);       // inversion underflows to 0
    settle();
    write_reg(REG_PMAX, 32'd65535);
    write_reg(REG_FRAME, 32'd65535);
    send_capture(2'd1, 16'd0);
    send_capture(2'd1, 16'd65535);   // largest plain width
    settle();
  endtask

  // Output held off while the source keeps offering pulses back to back.
  task automatic test_backpressure();
    src_idle = 1'b0;
    hold_len = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      send_capture(CH_W'(i % 4), CAP_W'($urandom));
      send_capture(CH_W'(i % 4), CAP_W'($urandom));
    end
    settle();
    src_idle = 1'b1;
  endtask

  // Random phases, each with its own register set and idle mix.
  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      random_config();
      src_idle  = (phase % 3) != 2;
      sink_idle = (phase % 3) != 1;
      random_captures(260);
      settle();
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    random_config();
    random_captures(200);
    settle();
  endtask

  initial begin
    // predictor at reset state
    cfg_period = PERIOD_RST;
    cfg_clk    = CLK_RST;
    cfg_pmax   = PMAX_RST;
    cfg_frame  = FRAME_RST;
    edge_open  = '0;
    foreach (edge_start[i]) edge_start[i] = '0;
    // all inputs known from time 0
    rst_ni  <= 1'b0;
    s_valid <= 1'b0;
    s_data  <= '0;
    s_user  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_pairs();
    test_corner_configs();
    test_backpressure();
    test_random_phases();
    test_full_rate();

    if (errors == 0) begin
      $display("rc_pwm_pulse_width_capture_unit test passed");
    end else begin
      $display("rc_pwm_pulse_width_capture_unit test failed");
    end
    $finish;
  end

endmodule
